// ===== rtl/mksd_pkg.sv =====
package mksd_pkg;

	localparam int ColW  = 3;
	localparam int RowW  = 4;
	localparam int CharW = 6;
	localparam int CntW  = 8;

	localparam logic [CntW-1:0] DebounceReset = 8'd25;
	localparam logic [CntW-1:0] CntMax        = 8'hFF;

	typedef logic [ColW-1:0]  col_t;
	typedef logic [RowW-1:0]  row_t;
	typedef logic [CharW-1:0] char_t;
	typedef logic [CntW-1:0]  cnt_t;

	// scanner states, one-hot
	typedef enum logic [7:0] {
		ST_SCAN0    = 8'b0000_0001,
		ST_SCAN1    = 8'b0000_0010,
		ST_SCAN2    = 8'b0000_0100,
		ST_SCAN3    = 8'b0000_1000,
		ST_CLEAR    = 8'b0001_0000,
		ST_PRESS_DB = 8'b0010_0000,
		ST_WAIT_REL = 8'b0100_0000,
		ST_REL_DB   = 8'b1000_0000
	} scan_state_t;

	typedef struct packed {
		row_t  row_drive;
		logic  key_held;
		char_t key_char;
	} result_t;

	// first low column, column 2 when none is low
	function automatic logic [1:0] first_low_col(input col_t cols);
		logic [1:0] c;
		if (!cols[0]) begin
			c = 2'd0;
		end else if (!cols[1]) begin
			c = 2'd1;
		end else begin
			c = 2'd2;
		end
		return c;
	endfunction

	// key legend by row and column
	function automatic char_t key_lookup(input logic [1:0] row, input logic [1:0] col);
		char_t ch;
		case ({row, col})
			4'b00_00: ch = 6'(8'h31);
			4'b00_01: ch = 6'(8'h32);
			4'b00_10: ch = 6'(8'h33);
			4'b01_00: ch = 6'(8'h34);
			4'b01_01: ch = 6'(8'h35);
			4'b01_10: ch = 6'(8'h36);
			4'b10_00: ch = 6'(8'h37);
			4'b10_01: ch = 6'(8'h38);
			4'b10_10: ch = 6'(8'h39);
			4'b11_00: ch = 6'(8'h2A);
			4'b11_01: ch = 6'(8'h30);
			4'b11_10: ch = 6'(8'h23);
			default:  ch = 6'(8'h23);
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/mksd_if.sv =====
interface mksd_in_if;
	import mksd_pkg::*;
	logic valid;
	logic ready;
	col_t col_lines;
	logic tick;

	modport source (output valid, output col_lines, output tick, input ready);
	modport sink   (input valid, input col_lines, input tick, output ready);
endinterface

interface mksd_out_if;
	import mksd_pkg::*;
	logic  valid;
	logic  ready;
	row_t  row_drive;
	logic  key_held;
	char_t key_char;

	modport source (output valid, output row_drive, output key_held, output key_char,
		input ready);
	modport sink   (input valid, input row_drive, input key_held, input key_char,
		output ready);
endinterface

interface mksd_cfg_if;
	import mksd_pkg::*;
	logic valid;
	logic ready;
	cnt_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/matrix_keypad_scan_debounce_unit.sv =====
// channel   dir  payload                            transaction
// item      in   col_lines[2:0], tick               valid & ready
// result    out  row_drive[3:0], key_held, key_char valid & ready
// cfg       in   data[7:0] (debounce_ticks)         valid & ready
//
// one item per cycle while item.ready is high: scan state and counter
// update in the accept cycle, the result is registered into the queue.
// a two-entry result queue (head plus skid) lets an item be taken while a
// result waits; item.ready drops only when both entries are full.
// cfg is always ready. reset: scanning row 0, no row driven, debounce 25.
module matrix_keypad_scan_debounce_unit (
	input logic clk,
	input logic arst_n,
	mksd_in_if.sink     item,
	mksd_out_if.source  result,
	mksd_cfg_if.sink    cfg
);
	import mksd_pkg::*;

	scan_state_t state_q, state_d;
	logic [1:0]  cur_row_q, cur_row_d;
	row_t        row_q, row_d;
	cnt_t        tick_q, tick_d;
	logic        held_q, held_d;
	cnt_t        debounce_q;

	result_t     res_new;
	result_t     head_s1, skid_q;
	logic        head_vld_s1, skid_vld_q;

	logic        accept, pop;
	logic        pressed, elapsed, clr;
	logic [1:0]  scan_row;

	assign accept  = item.valid && item.ready;
	assign pop     = head_vld_s1 && result.ready;
	assign pressed = (item.col_lines != 3'b111);
	assign elapsed = (tick_q >= debounce_q);

	// config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DebounceReset;
		end else if (cfg.valid) begin
			debounce_q <= cfg.data;
		end
	end

	// row index of the scan state
	always_comb begin
		case (state_q)
			ST_SCAN1: scan_row = 2'd1;
			ST_SCAN2: scan_row = 2'd2;
			ST_SCAN3: scan_row = 2'd3;
			default:  scan_row = 2'd0;
		endcase
	end

	// next-state logic for one item
	always_comb begin
		state_d   = state_q;
		cur_row_d = cur_row_q;
		row_d     = row_q;
		held_d    = held_q;
		clr       = 1'b0;
		case (state_q)
			ST_SCAN0, ST_SCAN1, ST_SCAN2, ST_SCAN3: begin
				if (!pressed) begin
					row_d     = ~(row_t'(1) << scan_row);
					cur_row_d = scan_row;
					case (scan_row)
						2'd0:    state_d = ST_SCAN1;
						2'd1:    state_d = ST_SCAN2;
						2'd2:    state_d = ST_SCAN3;
						default: state_d = ST_SCAN0;
					endcase
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				clr     = 1'b1;
				state_d = ST_PRESS_DB;
			end
			ST_PRESS_DB: begin
				if (elapsed) begin
					if (!pressed) begin
						state_d = ST_SCAN0;
					end else begin
						held_d  = 1'b1;
						state_d = ST_WAIT_REL;
					end
				end
			end
			ST_WAIT_REL: begin
				if (!pressed) begin
					clr     = 1'b1;
					state_d = ST_REL_DB;
				end
			end
			ST_REL_DB: begin
				if (elapsed) begin
					if (!pressed) begin
						held_d  = 1'b0;
						state_d = ST_SCAN0;
					end else begin
						state_d = ST_WAIT_REL;
					end
				end
			end
			default: begin
				state_d = ST_SCAN0;
			end
		endcase

		// saturating tick counter, a clear drops this tick
		if (clr) begin
			tick_d = '0;
		end else if (item.tick && (tick_q != CntMax)) begin
			tick_d = tick_q + cnt_t'(1);
		end else begin
			tick_d = tick_q;
		end

		res_new.row_drive = row_d;
		res_new.key_held  = held_d;
		res_new.key_char  = key_lookup(cur_row_d, first_low_col(item.col_lines));
	end

	// scanner state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SCAN0;
			cur_row_q <= '0;
			row_q     <= '1;
			tick_q    <= '0;
			held_q    <= 1'b0;
		end else if (accept) begin
			state_q   <= state_d;
			cur_row_q <= cur_row_d;
			row_q     <= row_d;
			tick_q    <= tick_d;
			held_q    <= held_d;
		end
	end

	// result queue valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_s1 <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (pop) begin
			head_vld_s1 <= skid_vld_q || accept;
			skid_vld_q  <= skid_vld_q && accept;
		end else if (accept) begin
			head_vld_s1 <= 1'b1;
			skid_vld_q  <= head_vld_s1;
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (pop) begin
			head_s1 <= skid_vld_q ? skid_q : res_new;
			if (skid_vld_q) begin
				skid_q <= res_new;
			end
		end else if (accept) begin
			if (head_vld_s1) begin
				skid_q <= res_new;
			end else begin
				head_s1 <= res_new;
			end
		end
	end

	assign item.ready       = !skid_vld_q;
	assign result.valid     = head_vld_s1;
	assign result.row_drive = head_s1.row_drive;
	assign result.key_held  = head_s1.key_held;
	assign result.key_char  = head_s1.key_char;

`ifndef SYNTHESIS
	a_held_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == ((state_q == ST_WAIT_REL) || (state_q == ST_REL_DB)))
		else $error("held flag disagrees with scan state");

	a_one_row_driven: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(~row_q))
		else $error("more than one row driven");

	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> head_vld_s1)
		else $error("skid entry without head entry");

	a_count_only_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(tick_q))
		else $error("tick counter moved without a transaction");
`endif

endmodule
